// ===== rtl/ssi_pkg.sv =====
// Shared types and constants for the segment intersection classifier.
`timescale 1ns / 1ps
package ssi_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int PT_BITS        = 48;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_PROPER = 2'd1,
    KIND_TOUCH  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  pv;
  } ssi_tag_t;

endpackage

// ===== rtl/ssi_if.sv =====
// Channel interfaces: segment pair words in, classification words out.
`timescale 1ns / 1ps
interface ssi_pair_if import ssi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;

  modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
  modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

interface ssi_res_if import ssi_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic                      point_valid;
  logic signed [PT_BITS-1:0] point_x;
  logic signed [PT_BITS-1:0] point_y;

  modport source (output valid, kind, point_valid, point_x, point_y, input ready);
  modport sink   (input valid, kind, point_valid, point_x, point_y, output ready);
endinterface

// ===== rtl/ssi_front.sv =====
// Front pipeline: cross products, classification and point numerators.
`timescale 1ns / 1ps
module ssi_front import ssi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DEN_W      = 2 * COORD_BITS + 3,
  parameter int NUM_W      = COORD_BITS + DEN_W + 2 + FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y,
  output logic                         out_valid,
  output logic [1:0][NUM_W-1:0]        num_mag,
  output logic [1:0]                   num_neg,
  output logic [DEN_W-1:0]             den_mag,
  output logic                         den_neg,
  output ssi_tag_t                     tag
);
  localparam int C     = COORD_BITS;
  localparam int DIF_W = C + 1;
  localparam int PRD_W = 2 * C + 1;
  localparam int DMN_W = DEN_W + 1;
  localparam int MUL_W = C + DEN_W + 1;
  localparam int SUM_W = MUL_W + 1;

  logic [7:0] v;

  // stage 1: captured coordinates
  logic signed [C-1:0] ax1, ay1, bx1, by1, cx1, cy1, dx1, dy1;
  // stage 2: differences
  logic signed [C-1:0]     ax2, ay2, bx2, by2, cx2, dx2;
  logic signed [DIF_W-1:0] dyc, cyd, bya, ayb, ayd, cya, cyb, ayc;
  // stage 3: products
  logic signed [C-1:0]     ax3, ay3, bx3, by3;
  logic signed [PRD_W-1:0] p0, p1, p2, p3, p4, p5, p6, p7, p8;
  // stage 4: sums
  logic signed [C-1:0]     ax4, ay4, bx4, by4;
  logic signed [DEN_W-1:0] den4, ns4, nt4;
  // stage 5: classification
  logic signed [C-1:0]     ax5, ay5, bx5, by5;
  logic signed [DMN_W-1:0] dmn5;
  logic signed [DEN_W-1:0] ns5;
  logic [DEN_W-1:0]        dmag5;
  logic                    dneg5;
  ssi_tag_t                tag5, tag_next;
  // stage 6: point products
  logic signed [MUL_W-1:0] max6, mbx6, may6, mby6;
  logic [DEN_W-1:0]        dmag6;
  logic                    dneg6;
  ssi_tag_t                tag6;
  // stage 7: point numerators
  logic signed [SUM_W-1:0] xs7, ys7;
  logic [DEN_W-1:0]        dmag7;
  logic                    dneg7;
  ssi_tag_t                tag7;
  // stage 8: shifted magnitudes
  logic signed [NUM_W-1:0] xn, yn;

  assign xn = NUM_W'(xs7) <<< FRAC_BITS;
  assign yn = NUM_W'(ys7) <<< FRAC_BITS;

  always_comb begin
    logic s_in, t_in;
    s_in = 1'b0;
    t_in = 1'b0;
    tag_next.kind = KIND_NONE;
    tag_next.pv   = 1'b0;
    if (den4 == '0) begin
      tag_next.kind = KIND_NONE;
    end else if (ns4 == '0 || ns4 == den4 || nt4 == '0 || nt4 == den4) begin
      tag_next.kind = KIND_TOUCH;
    end else begin
      if (!den4[DEN_W-1]) begin
        s_in = (ns4 > 0) && (ns4 < den4);
        t_in = (nt4 > 0) && (nt4 < den4);
      end else begin
        s_in = (ns4 < 0) && (ns4 > den4);
        t_in = (nt4 < 0) && (nt4 > den4);
      end
      tag_next.kind = (s_in && t_in) ? KIND_PROPER : KIND_NONE;
      tag_next.pv   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= a_x; ay1 <= a_y; bx1 <= b_x; by1 <= b_y;
      cx1 <= c_x; cy1 <= c_y; dx1 <= d_x; dy1 <= d_y;

      ax2 <= ax1; ay2 <= ay1; bx2 <= bx1; by2 <= by1; cx2 <= cx1; dx2 <= dx1;
      dyc <= DIF_W'(dy1) - DIF_W'(cy1);
      cyd <= DIF_W'(cy1) - DIF_W'(dy1);
      bya <= DIF_W'(by1) - DIF_W'(ay1);
      ayb <= DIF_W'(ay1) - DIF_W'(by1);
      ayd <= DIF_W'(ay1) - DIF_W'(dy1);
      cya <= DIF_W'(cy1) - DIF_W'(ay1);
      cyb <= DIF_W'(cy1) - DIF_W'(by1);
      ayc <= DIF_W'(ay1) - DIF_W'(cy1);

      ax3 <= ax2; ay3 <= ay2; bx3 <= bx2; by3 <= by2;
      p0 <= PRD_W'(ax2) * PRD_W'(dyc);
      p1 <= PRD_W'(bx2) * PRD_W'(cyd);
      p2 <= PRD_W'(dx2) * PRD_W'(bya);
      p3 <= PRD_W'(cx2) * PRD_W'(ayb);
      p4 <= PRD_W'(cx2) * PRD_W'(ayd);
      p5 <= PRD_W'(dx2) * PRD_W'(cya);
      p6 <= PRD_W'(ax2) * PRD_W'(cyb);
      p7 <= PRD_W'(bx2) * PRD_W'(ayc);
      p8 <= PRD_W'(cx2) * PRD_W'(bya);

      ax4 <= ax3; ay4 <= ay3; bx4 <= bx3; by4 <= by3;
      den4 <= DEN_W'(p0) + DEN_W'(p1) + DEN_W'(p2) + DEN_W'(p3);
      ns4  <= DEN_W'(p0) + DEN_W'(p4) + DEN_W'(p5);
      nt4  <= -(DEN_W'(p6) + DEN_W'(p7) + DEN_W'(p8));

      ax5 <= ax4; ay5 <= ay4; bx5 <= bx4; by5 <= by4;
      dmn5  <= DMN_W'(den4) - DMN_W'(ns4);
      ns5   <= ns4;
      dmag5 <= den4[DEN_W-1] ? DEN_W'(-den4) : DEN_W'(den4);
      dneg5 <= den4[DEN_W-1];
      tag5  <= tag_next;

      max6 <= MUL_W'(ax5) * MUL_W'(dmn5);
      mbx6 <= MUL_W'(bx5) * MUL_W'(ns5);
      may6 <= MUL_W'(ay5) * MUL_W'(dmn5);
      mby6 <= MUL_W'(by5) * MUL_W'(ns5);
      dmag6 <= dmag5; dneg6 <= dneg5; tag6 <= tag5;

      xs7 <= SUM_W'(max6) + SUM_W'(mbx6);
      ys7 <= SUM_W'(may6) + SUM_W'(mby6);
      dmag7 <= dmag6; dneg7 <= dneg6; tag7 <= tag6;

      num_neg[0] <= xn[NUM_W-1];
      num_neg[1] <= yn[NUM_W-1];
      num_mag[0] <= xn[NUM_W-1] ? NUM_W'(-xn) : NUM_W'(xn);
      num_mag[1] <= yn[NUM_W-1] ? NUM_W'(-yn) : NUM_W'(yn);
      den_mag <= dmag7; den_neg <= dneg7; tag <= tag7;
    end
  end

  assign out_valid = v[7];

endmodule

// ===== rtl/ssi_div.sv =====
// Pipelined restoring divider, two lanes sharing one divisor, one bit a stage.
`timescale 1ns / 1ps
module ssi_div import ssi_pkg::*; #(
  parameter int NUM_W = 69,
  parameter int DEN_W = 35
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [1:0][NUM_W-1:0] num_mag,
  input  logic [1:0]            num_neg,
  input  logic [DEN_W-1:0]      den_mag,
  input  logic                  den_neg,
  input  ssi_tag_t              in_tag,
  output logic                  out_valid,
  output logic [1:0][NUM_W-1:0] quo,
  output logic [1:0]            neg,
  output ssi_tag_t              out_tag
);
  logic                  v_s   [1:NUM_W];
  logic [1:0][DEN_W-1:0] rem_s [1:NUM_W];
  logic [1:0][NUM_W-1:0] num_s [1:NUM_W];
  logic [1:0][NUM_W-1:0] q_s   [1:NUM_W];
  logic [DEN_W-1:0]      d_s   [1:NUM_W];
  logic [1:0]            neg_s [1:NUM_W];
  ssi_tag_t              tag_s [1:NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic                  v_i;
    logic [1:0][DEN_W-1:0] rem_i, rem_n;
    logic [1:0][NUM_W-1:0] num_i, q_i, q_n;
    logic [DEN_W-1:0]      d_i;
    logic [1:0]            neg_i;
    ssi_tag_t              tag_i;

    if (k == 0) begin : g_head
      assign v_i   = in_valid;
      assign rem_i = '0;
      assign num_i = num_mag;
      assign q_i   = '0;
      assign d_i   = den_mag;
      assign neg_i = num_neg ^ {den_neg, den_neg};
      assign tag_i = in_tag;
    end else begin : g_body
      assign v_i   = v_s[k];
      assign rem_i = rem_s[k];
      assign num_i = num_s[k];
      assign q_i   = q_s[k];
      assign d_i   = d_s[k];
      assign neg_i = neg_s[k];
      assign tag_i = tag_s[k];
    end

    always_comb begin
      logic [DEN_W:0] r2, sub;
      logic           ge;
      r2  = '0;
      sub = '0;
      ge  = 1'b0;
      for (int l = 0; l < 2; l++) begin
        r2  = {rem_i[l], num_i[l][NUM_W-1]};
        sub = r2 - {1'b0, d_i};
        ge  = (r2 >= {1'b0, d_i});
        rem_n[l] = ge ? sub[DEN_W-1:0] : r2[DEN_W-1:0];
        q_n[l]   = {q_i[l][NUM_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= rem_n;
        num_s[k+1] <= {num_i[1][NUM_W-2:0], 1'b0, num_i[0][NUM_W-2:0], 1'b0};
        q_s[k+1]   <= q_n;
        d_s[k+1]   <= d_i;
        neg_s[k+1] <= neg_i;
        tag_s[k+1] <= tag_i;
      end
    end
  end

  assign out_valid = v_s[NUM_W];
  assign quo       = q_s[NUM_W];
  assign neg       = neg_s[NUM_W];
  assign out_tag   = tag_s[NUM_W];

endmodule

// ===== rtl/segment_segment_intersection.sv =====
// Top level: segment pair intersection classifier with fixed-point crossing point.
//
//   channel   dir  word contents
//   pairs     in   a_x a_y b_x b_y c_x c_y d_x d_y  (signed, COORD_BITS each)
//   results   out  kind, point_valid, point_x, point_y (signed 48-bit fixed point)
//
// One word enters per cycle while results are not stalled; the path runs through
// the eight front stages, one divider stage per numerator bit and the output
// register. Reset clears every valid bit; payload is not reset.
// A stalled result holds the whole pipeline in place, so nothing is lost or
// repeated; pairs.ready is high whenever the output register is free or taken.
`timescale 1ns / 1ps
module segment_segment_intersection import ssi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  ssi_pair_if.sink  pairs,
  ssi_res_if.source results
);
  localparam int DEN_W = 2 * COORD_BITS + 3;
  localparam int NUM_W = COORD_BITS + DEN_W + 2 + FRAC_BITS;
  localparam int QE_W  = NUM_W + PT_BITS;

  logic en;

  logic                  f_valid;
  logic [1:0][NUM_W-1:0] f_mag;
  logic [1:0]            f_neg;
  logic [DEN_W-1:0]      f_dmag;
  logic                  f_dneg;
  ssi_tag_t              f_tag;

  logic                  q_valid;
  logic [1:0][NUM_W-1:0] q_quo;
  logic [1:0]            q_neg;
  ssi_tag_t              q_tag;

  logic [1:0][PT_BITS-1:0] pt_next;

  logic               out_v;
  logic [1:0]         kind;
  logic               pv;
  logic [PT_BITS-1:0] px, py;

  // advance everything unless a finished word is waiting on the sink
  assign en          = !out_v || results.ready;
  assign pairs.ready = en;

  ssi_front #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .DEN_W     (DEN_W),
    .NUM_W     (NUM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pairs.valid),
    .a_x      (pairs.a_x),
    .a_y      (pairs.a_y),
    .b_x      (pairs.b_x),
    .b_y      (pairs.b_y),
    .c_x      (pairs.c_x),
    .c_y      (pairs.c_y),
    .d_x      (pairs.d_x),
    .d_y      (pairs.d_y),
    .out_valid(f_valid),
    .num_mag  (f_mag),
    .num_neg  (f_neg),
    .den_mag  (f_dmag),
    .den_neg  (f_dneg),
    .tag      (f_tag)
  );

  ssi_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .num_mag  (f_mag),
    .num_neg  (f_neg),
    .den_mag  (f_dmag),
    .den_neg  (f_dneg),
    .in_tag   (f_tag),
    .out_valid(q_valid),
    .quo      (q_quo),
    .neg      (q_neg),
    .out_tag  (q_tag)
  );

  // saturate each quotient to the signed 48-bit range, then apply the sign
  always_comb begin
    logic [QE_W-1:0] lim, qe, sat;
    lim = '0;
    qe  = '0;
    sat = '0;
    for (int l = 0; l < 2; l++) begin
      lim = (QE_W'(1) << (PT_BITS - 1)) - (q_neg[l] ? QE_W'(0) : QE_W'(1));
      qe  = QE_W'(q_quo[l]);
      sat = (qe > lim) ? lim : qe;
      pt_next[l] = q_neg[l] ? -sat[PT_BITS-1:0] : sat[PT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= q_valid;
    end
  end

  // the point is only meaningful when computed; drop it to zero otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      kind <= q_tag.kind;
      pv   <= q_tag.pv;
      px   <= q_tag.pv ? pt_next[0] : '0;
      py   <= q_tag.pv ? pt_next[1] : '0;
    end
  end

  assign results.valid       = out_v;
  assign results.kind        = kind;
  assign results.point_valid = pv;
  assign results.point_x     = px;
  assign results.point_y     = py;

`ifndef SYNTH
  a_proper_has_point: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.kind == KIND_PROPER |-> results.point_valid)
    else $error("proper crossing without a point");

  a_no_point_is_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.point_valid |-> results.point_x == '0 && results.point_y == '0)
    else $error("point not zero while not computed");

  a_touch_no_point: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.kind == KIND_TOUCH |-> !results.point_valid)
    else $error("endpoint touch carries a point");
`endif

endmodule
